/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the temperature converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tadc_pkg.sv */
// Shared types and constants of the thermistor temperature converter.
`timescale 1ns / 1ps

package tadc_pkg;

  // Register file geometry.
  localparam int REG_W = 26;
  localparam int IDX_W = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_NUM_ONE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_NUM_TWO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_NUM_THREE = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEN_ONE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEN_TWO   = 3'd5;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd6;

  // Reset values: the default fit in signed Q16.
  localparam logic signed [REG_W-1:0] RST_NUM_ONE   = -26'sd7091651;
  localparam logic signed [REG_W-1:0] RST_NUM_TWO   = 26'sd1580597;
  localparam logic signed [REG_W-1:0] RST_NUM_THREE = 26'sd14180680;
  localparam logic signed [REG_W-1:0] RST_DEN_ONE   = 26'sd2553;
  localparam logic signed [REG_W-1:0] RST_DEN_TWO   = -26'sd208431;
  localparam logic signed [REG_W-1:0] RST_OFFSET    = 26'sd1638400;

  // Width of the Horner partial sums and of the denominator.
  localparam int DW = 28;

  // Result format.
  localparam int OUT_W  = 16;
  localparam int Q_BITS = OUT_W - 1;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  // Linear mode: 100 * 3300 / 2.5 and 100 * (760 / 2.5 - 25).
  localparam int LIN_SCALE_W = 18;
  localparam logic [LIN_SCALE_W-1:0] LIN_SCALE = 18'd132000;
  localparam int LIN_BIAS = 27900;

  // Control that travels with an item between the pipeline sections.
  typedef struct packed {
    logic valid;
    logic linear;
  } tadc_ctl_t;

  // A finished temperature with its range flag.
  typedef struct packed {
    logic signed [OUT_W-1:0] temp;
    logic                    flag;
  } tadc_res_t;

endpackage

/* rtl/tadc_in_if.sv */
// Input channel carrying one raw ADC reading per item.
`timescale 1ns / 1ps

interface tadc_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_reading;

  modport source (output valid, output adc_reading, input ready);
  modport sink (input valid, input adc_reading, output ready);
endinterface

/* rtl/tadc_out_if.sv */
// Output channel carrying one temperature result per item.
`timescale 1ns / 1ps

interface tadc_out_if;
  import tadc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] temperature_centi;
  logic                    out_of_range;

  modport source (output valid, output temperature_centi, output out_of_range, input ready);
  modport sink (input valid, input temperature_centi, input out_of_range, output ready);
endinterface

/* rtl/tadc_horner.sv */
// Horner evaluation of numerator and denominator, plus the linear mode lane.
`timescale 1ns / 1ps

module tadc_horner #(
  parameter int ADC_BITS       = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  tadc_pkg::tadc_ctl_t                 in_ctl,
  input  logic [ADC_BITS-1:0]                 reading,
  input  logic signed [tadc_pkg::REG_W-1:0]   num_one,
  input  logic signed [tadc_pkg::REG_W-1:0]   num_two,
  input  logic signed [tadc_pkg::REG_W-1:0]   num_three,
  input  logic signed [tadc_pkg::REG_W-1:0]   den_one,
  input  logic signed [tadc_pkg::REG_W-1:0]   den_two,
  output tadc_pkg::tadc_ctl_t                 out_ctl,
  output logic signed [tadc_pkg::DW-1:0]      nu,
  output logic signed [tadc_pkg::DW-1:0]      den,
  output tadc_pkg::tadc_res_t                 lin_res
);
  import tadc_pkg::*;

  localparam int NS   = 7;
  localparam int XSW  = ADC_BITS + 1;
  localparam int PRW  = XSW + DW;
  localparam int LPW  = ADC_BITS + LIN_SCALE_W;
  localparam int LTW  = LIN_SCALE_W + 1;
  localparam int HALF = 1 << (ADC_BITS - 1);
  localparam logic signed [DW-1:0] ONE = DW'(64'sd1 << COEF_FRAC_BITS);

  // Product divided by the reading scale, rounded half up.
  function automatic logic signed [DW-1:0] rnd(input logic signed [PRW-1:0] prod);
    logic signed [PRW-1:0] t;
    t = prod + PRW'(HALF);
    return DW'(t >>> ADC_BITS);
  endfunction

  tadc_ctl_t               ctl [1:NS];
  logic signed [XSW-1:0]   xs [1:5];
  logic signed [XSW-1:0]   xs_next;
  logic [LPW-1:0]          lin_prod;
  logic signed [LTW-1:0]   lin_t;
  tadc_res_t               lin_sat;
  tadc_res_t               lin_q [3:NS];
  logic signed [PRW-1:0]   pa2, pb2, pa4, pb4, pa6;
  logic signed [DW-1:0]    p2, q1, p1, d5, d6, nu7, d7;

  // Reading recentred on mid scale.
  assign xs_next = $signed({1'b0, reading}) - XSW'(HALF);

  // Clamp of the linear temperature to the output range.
  always_comb begin
    priority if (lin_t > LTW'(OUT_MAX)) begin
      lin_sat = '{temp: OUT_MAX, flag: 1'b1};
    end else if (lin_t < LTW'(OUT_MIN)) begin
      lin_sat = '{temp: OUT_MIN, flag: 1'b1};
    end else begin
      lin_sat = '{temp: OUT_W'(lin_t), flag: 1'b0};
    end
  end

  // Control and valid bits move one stage per enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NS; k++) ctl[k] <= '0;
    end else if (en) begin
      ctl[1] <= in_ctl;
      for (int k = 2; k <= NS; k++) ctl[k] <= ctl[k-1];
    end
  end

  // Datapath stages: multiply, then round and add, twice over; the third time the numerator is only rounded.
  always_ff @(posedge clk) begin
    if (en) begin
      xs[1]    <= xs_next;
      for (int k = 2; k <= 5; k++) xs[k] <= xs[k-1];
      lin_prod <= LPW'(reading) * LPW'(LIN_SCALE);

      pa2   <= xs[1] * DW'(num_three);
      pb2   <= xs[1] * DW'(den_two);
      lin_t <= $signed(LTW'((lin_prod + LPW'(HALF)) >> ADC_BITS)) - LTW'(LIN_BIAS);

      p2       <= DW'(num_two) + rnd(pa2);
      q1       <= DW'(den_one) + rnd(pb2);
      lin_q[3] <= lin_sat;
      for (int k = 4; k <= NS; k++) lin_q[k] <= lin_q[k-1];

      pa4 <= xs[3] * p2;
      pb4 <= xs[3] * q1;

      p1 <= DW'(num_one) + rnd(pa4);
      d5 <= ONE + rnd(pb4);

      pa6 <= xs[5] * p1;
      d6  <= d5;

      nu7 <= rnd(pa6);
      d7  <= d6;
    end
  end

  assign out_ctl = ctl[NS];
  assign nu      = nu7;
  assign den     = d7;
  assign lin_res = lin_q[NS];

endmodule

/* rtl/tadc_ratio.sv */
// Offset plus ratio, scaled by one hundred, with a bit-per-stage divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tadc_ratio #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  tadc_pkg::tadc_ctl_t               in_ctl,
  input  logic signed [tadc_pkg::DW-1:0]    nu,
  input  logic signed [tadc_pkg::DW-1:0]    den,
  input  tadc_pkg::tadc_res_t               lin_res,
  input  logic signed [tadc_pkg::REG_W-1:0] offset,
  output logic                              out_valid,
  output tadc_pkg::tadc_res_t               res
);
  import tadc_pkg::*;

  localparam int QB = Q_BITS;
  localparam int OW = REG_W + DW;
  localparam int SW = ((OW > DW + COEF_FRAC_BITS) ? OW : DW + COEF_FRAC_BITS) + 1;
  localparam int XW = SW + 9;
  localparam int MW = XW - COEF_FRAC_BITS - 1;
  localparam int HW = MW - QB;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam tadc_res_t DEN_BAD = '{temp: '0, flag: 1'b1};

  // Front stages: numerator of the final ratio and its magnitude.
  logic                  e_vld [1:4];
  logic                  e_byp [1:4];
  tadc_res_t             e_res [1:4];
  logic signed [DW-1:0]  e_d   [1:4];
  logic signed [DW-1:0]  nu1;
  logic signed [OW-1:0]  od1;
  logic signed [SW-1:0]  s2;
  logic signed [XW-1:0]  x3;
  logic signed [XW-1:0]  sx;
  logic signed [XW-1:0]  xsh;
  logic [MW-1:0]         m4;
  logic                  neg4;

  // Divider stages: index 0 holds the range check, 1 to QB one quotient bit each.
  logic                  st_valid [0:QB];
  logic                  st_byp   [0:QB];
  logic                  st_neg   [0:QB];
  logic                  st_over  [0:QB];
  tadc_res_t             st_res   [0:QB];
  logic [DW-1:0]         st_r     [0:QB];
  logic [DW-1:0]         st_d     [0:QB];
  logic [QB-1:0]         st_q     [0:QB];
  logic [QB-1:0]         st_m     [0:QB];
  logic [CW-1:0]         hi_ext;
  logic [CW-1:0]         d_ext;

  assign sx     = XW'(s2);
  assign xsh    = x3 >>> (COEF_FRAC_BITS + 1);
  assign hi_ext = CW'(m4[MW-1:QB]);
  assign d_ext  = CW'($unsigned(e_d[4]));

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 4; k++) e_vld[k] <= 1'b0;
      st_valid[0] <= 1'b0;
    end else if (en) begin
      e_vld[1] <= in_ctl.valid;
      for (int k = 2; k <= 4; k++) e_vld[k] <= e_vld[k-1];
      st_valid[0] <= e_vld[4];
    end
  end

  // Front datapath. Linear items and a non-positive denominator bypass the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      e_byp[1] <= in_ctl.linear || den[DW-1] || (den == '0);
      e_res[1] <= in_ctl.linear ? lin_res : DEN_BAD;
      e_d[1]   <= den;
      nu1      <= nu;
      od1      <= offset * den;
      for (int k = 2; k <= 4; k++) begin
        e_byp[k] <= e_byp[k-1];
        e_res[k] <= e_res[k-1];
        e_d[k]   <= e_d[k-1];
      end

      s2 <= SW'(od1) + (SW'(nu1) <<< COEF_FRAC_BITS);

      // Times two hundred, plus the half-divisor for rounding.
      x3 <= (sx <<< 7) + (sx <<< 6) + (sx <<< 3) + (XW'(e_d[2]) <<< COEF_FRAC_BITS);

      // Floor by the power of two, then fold a negative value onto its complement.
      neg4 <= x3[XW-1];
      m4   <= x3[XW-1] ? MW'(~xsh) : MW'(xsh);

      // Range check: the quotient must stay below two to the fifteenth.
      st_byp[0]  <= e_byp[4];
      st_res[0]  <= e_res[4];
      st_neg[0]  <= neg4;
      st_over[0] <= hi_ext >= d_ext;
      st_r[0]    <= hi_ext[DW-1:0];
      st_d[0]    <= $unsigned(e_d[4]);
      st_q[0]    <= '0;
      st_m[0]    <= m4[QB-1:0];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [DW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = {st_r[j-1][DW-2:0], st_m[j-1][QB-j]};
      ge    = trial >= st_d[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[j] <= 1'b0;
      end else if (en) begin
        st_valid[j] <= st_valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_byp[j]  <= st_byp[j-1];
        st_res[j]  <= st_res[j-1];
        st_neg[j]  <= st_neg[j-1];
        st_over[j] <= st_over[j-1];
        st_d[j]    <= st_d[j-1];
        st_m[j]    <= st_m[j-1];
        st_r[j]    <= ge ? trial - st_d[j-1] : trial;
        st_q[j]    <= {st_q[j-1][QB-2:0], ge};
      end
    end
  end

  // Sign restore and saturation of the quotient.
  always_comb begin
    res = st_res[QB];
    priority if (st_byp[QB]) begin
      res = st_res[QB];
    end else if (st_over[QB]) begin
      res.temp = st_neg[QB] ? OUT_MIN : OUT_MAX;
      res.flag = 1'b1;
    end else begin
      res.temp = st_neg[QB] ? $signed(~{1'b0, st_q[QB]}) : $signed({1'b0, st_q[QB]});
      res.flag = 1'b0;
    end
  end

  assign out_valid = st_valid[QB];

  `ASSERT_IMPLIES(a_den_positive, clk, rst, st_valid[0] && !st_byp[0], (st_d[0] != '0) && !st_d[0][DW-1], "divider entered with a non-positive denominator")
  `ASSERT_IMPLIES(a_rem_start, clk, rst, st_valid[0] && !st_byp[0] && !st_over[0], st_r[0] < st_d[0], "initial remainder not below the denominator")
  `ASSERT_IMPLIES(a_rem_end, clk, rst, st_valid[QB] && !st_byp[QB] && !st_over[QB], st_r[QB] < st_d[QB], "final remainder not below the denominator")

endmodule

/* rtl/thermistor_adc_to_temperature.sv */
// Top level of the thermistor ADC reading to temperature converter.
//
//   channel   direction  handshake          payload
//   sample    in         valid / ready      adc_reading
//   result    out        valid / ready      temperature_centi, out_of_range
//   cfg       in         cfg_write          cfg_index, cfg_data
//
// One item is taken per cycle while the result side does not stall. The 28
// registers on the way are seven Horner stages, four ratio stages, one range
// check, fifteen quotient stages (one bit each) and the output register.
// Reset clears the valid bits and loads the default fit; there is no clearing pass.
// A stall on the result side freezes the whole pipeline; one item still taken
// in that cycle waits in a skid register, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thermistor_adc_to_temperature #(
  parameter int ADC_BITS       = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  tadc_in_if.sink                           sample,
  tadc_out_if.source                        result,
  input  logic                              cfg_write,
  input  logic [tadc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [tadc_pkg::REG_W-1:0]        cfg_data
);
  import tadc_pkg::*;

  // Configuration registers.
  logic                    mode;
  logic signed [REG_W-1:0] num_one, num_two, num_three;
  logic signed [REG_W-1:0] den_one, den_two, offset;

  logic                    en;
  logic                    take;
  logic                    skid_valid;
  logic [ADC_BITS-1:0]     skid_reading;
  tadc_ctl_t               feed_ctl;
  logic [ADC_BITS-1:0]     feed_reading;

  tadc_ctl_t               h_ctl;
  logic signed [DW-1:0]    h_nu;
  logic signed [DW-1:0]    h_den;
  tadc_res_t               h_lin;
  logic                    r_valid;
  tadc_res_t               r_res;

  logic                    out_valid;
  tadc_res_t               out_res;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      num_one   <= RST_NUM_ONE;
      num_two   <= RST_NUM_TWO;
      num_three <= RST_NUM_THREE;
      den_one   <= RST_DEN_ONE;
      den_two   <= RST_DEN_TWO;
      offset    <= RST_OFFSET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:      mode      <= cfg_data[0];
        REG_NUM_ONE:   num_one   <= $signed(cfg_data);
        REG_NUM_TWO:   num_two   <= $signed(cfg_data);
        REG_NUM_THREE: num_three <= $signed(cfg_data);
        REG_DEN_ONE:   den_one   <= $signed(cfg_data);
        REG_DEN_TWO:   den_two   <= $signed(cfg_data);
        REG_OFFSET:    offset    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being emptied.
  assign en           = !out_valid || result.ready;
  assign sample.ready = !skid_valid;
  assign take         = sample.valid && !skid_valid;

  // The skid register catches an item taken while the pipeline is frozen.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && take) begin
      skid_reading <= sample.adc_reading;
    end
  end

  assign feed_ctl     = '{valid: skid_valid || take, linear: mode};
  assign feed_reading = skid_valid ? skid_reading : sample.adc_reading;

  tadc_horner #(
    .ADC_BITS       (ADC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_horner (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (feed_ctl),
    .reading   (feed_reading),
    .num_one   (num_one),
    .num_two   (num_two),
    .num_three (num_three),
    .den_one   (den_one),
    .den_two   (den_two),
    .out_ctl   (h_ctl),
    .nu        (h_nu),
    .den       (h_den),
    .lin_res   (h_lin)
  );

  tadc_ratio #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_ratio (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (h_ctl),
    .nu        (h_nu),
    .den       (h_den),
    .lin_res   (h_lin),
    .offset    (offset),
    .out_valid (r_valid),
    .res       (r_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= r_res;
    end
  end

  assign result.valid             = out_valid;
  assign result.temperature_centi = out_res.temp;
  assign result.out_of_range      = out_res.flag;

  `ASSERT_NEXT(a_skid_catch, clk, rst, sample.valid && sample.ready && !en, skid_valid, "item taken during a stall was not held in the skid register")
  `ASSERT_NEXT(a_skid_hold, clk, rst, skid_valid && !en, skid_valid && $stable(skid_reading), "skid item lost or changed during a stall")

endmodule

/* tb/tb_thermistor_adc_to_temperature.sv */
// Self-checking testbench for the thermistor ADC reading to temperature converter.
`timescale 1ns / 1ps

module tb_thermistor_adc_to_temperature;
  import tadc_pkg::*;

  localparam int ADC_BITS       = 12;
  localparam int COEF_FRAC_BITS = 16;

  localparam longint FULL_SCALE = longint'(1) << ADC_BITS;
  localparam longint UNITY      = longint'(1) << COEF_FRAC_BITS;
  localparam longint LIN_GAIN   = 132000;
  localparam longint LIN_OFFSET = 27900;
  localparam longint TEMP_MAX   = 32767;
  localparam longint TEMP_MIN   = -32768;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER  = 200;

  // Index past the end of the register list; writes to it must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic [REG_W-1:0] COEF_MIN = 26'h2000000;
  localparam logic [REG_W-1:0] COEF_MAX = 26'h1ffffff;

  // The coefficient registers in list order, with the default fit of each.
  localparam logic [IDX_W-1:0] COEF_REGS [6] = '{REG_NUM_ONE, REG_NUM_TWO, REG_NUM_THREE,
                                                 REG_DEN_ONE, REG_DEN_TWO, REG_OFFSET};
  localparam longint FIT_DEFAULT [6] = '{-7091651, 1580597, 14180680, 2553, -208431,
                                         1638400};

  logic clk = 1'b0;
  logic rst;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  tadc_in_if #(.ADC_BITS(ADC_BITS)) sample_ch ();
  tadc_out_if result_ch ();

  thermistor_adc_to_temperature #(
    .ADC_BITS      (ADC_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample_ch),
    .result   (result_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Local copy of the conversion settings.
  logic   lin_mode = 1'b0;
  longint a1  = -7091651;
  longint a2  = 1580597;
  longint a3  = 14180680;
  longint b1  = 2553;
  longint b2  = -208431;
  longint ofs = 1638400;

  logic [ADC_BITS-1:0] readings_q [$];
  tadc_res_t           temps_due [$];

  int   errs       = 0;
  int   results_in = 0;
  int   cycles     = 0;
  int   src_gap    = 0;
  int   snk_gap    = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;
  logic idle_on    = 1'b0;
  logic calm       = 1'b0;

  // Division rounded to nearest, ties toward plus infinity; the divisor is positive.
  function automatic longint round_half_up(longint n, longint d);
    longint num, den, q;
    num = 2 * n + d;
    den = 2 * d;
    q = num / den;
    if (num % den < 0) q -= 1;
    return q;
  endfunction

  // Expected temperature and flag for one reading under the current settings.
  function automatic tadc_res_t reading_to_centi(logic [ADC_BITS-1:0] rd);
    longint    xs, p, q, nu, d, t;
    logic      oor;
    tadc_res_t r;
    oor = 1'b0;
    if (lin_mode) begin
      t = round_half_up(longint'(rd) * LIN_GAIN, FULL_SCALE) - LIN_OFFSET;
    end else begin
      xs = longint'(rd) - FULL_SCALE / 2;
      p  = a2 + round_half_up(xs * a3, FULL_SCALE);
      p  = a1 + round_half_up(xs * p, FULL_SCALE);
      nu = round_half_up(xs * p, FULL_SCALE);
      q  = b1 + round_half_up(xs * b2, FULL_SCALE);
      d  = UNITY + round_half_up(xs * q, FULL_SCALE);
      if (d <= 0) begin
        // A denominator that is not positive gives zero with the flag raised.
        t   = 0;
        oor = 1'b1;
      end else begin
        t = round_half_up(100 * ofs * d + 100 * nu * UNITY, d * UNITY);
      end
    end
    if (t > TEMP_MAX) begin
      t   = TEMP_MAX;
      oor = 1'b1;
    end else if (t < TEMP_MIN) begin
      t   = TEMP_MIN;
      oor = 1'b1;
    end
    r.temp = t[OUT_W-1:0];
    r.flag = oor;
    return r;
  endfunction

  // Small random change around a default coefficient.
  function automatic logic [REG_W-1:0] nudge(longint base);
    longint span, v;
    span = (base < 0 ? -base : base) / 16 + 64;
    v = base + longint'($urandom_range(0, int'(2 * span))) - span;
    return v[REG_W-1:0];
  endfunction

  // Mostly uniform readings, with the ends and the midpoint now and then.
  function automatic logic [ADC_BITS-1:0] pick_reading();
    logic [ADC_BITS-1:0] rd;
    rd = ADC_BITS'($urandom_range(0, 32'(FULL_SCALE - 1)));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: rd = '0;
        1: rd = '1;
        2: rd = ADC_BITS'(FULL_SCALE / 2 - 1);
        default: rd = ADC_BITS'(FULL_SCALE / 2);
      endcase
    end
    return rd;
  endfunction

  // One register write, mirrored into the local settings once it has landed.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MODE:      lin_mode = val[0];
      REG_NUM_ONE:   a1  = longint'(signed'(val));
      REG_NUM_TWO:   a2  = longint'(signed'(val));
      REG_NUM_THREE: a3  = longint'(signed'(val));
      REG_DEN_ONE:   b1  = longint'(signed'(val));
      REG_DEN_TWO:   b2  = longint'(signed'(val));
      REG_OFFSET:    ofs = longint'(signed'(val));
      default: ;
    endcase
  endtask

  // Wait until every queued item is taken and every result has come back.
  task automatic settle();
    while (readings_q.size() != 0 || sample_ch.valid || temps_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: offers queued readings and predicts each accepted one.
  always @(posedge clk) begin : sender
    logic take;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      take = sample_ch.valid && sample_ch.ready;
      if (take) temps_due.push_back(reading_to_centi(readings_q.pop_front()));
      if (!take && sample_ch.valid) begin
        // The offered item stays on the channel until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        sample_ch.valid <= 1'b0;
      end else if (readings_q.size() == 0) begin
        sample_ch.valid <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 6);
        sample_ch.valid <= 1'b0;
      end else begin
        sample_ch.valid       <= 1'b1;
        sample_ch.adc_reading <= readings_q[0];
      end
    end
  end

  // Receiver: checks each result against the oldest prediction and paces ready.
  always @(posedge clk) begin : receiver
    tadc_res_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_in++;
        if (temps_due.size() == 0) begin
          $error("result with no item outstanding: temperature_centi %0d out_of_range %0b",
                 result_ch.temperature_centi, result_ch.out_of_range);
          errs++;
        end else begin
          want = temps_due.pop_front();
          if (result_ch.temperature_centi !== want.temp) begin
            $error("temperature_centi: expected %0d, got %0d", $signed(want.temp),
                   $signed(result_ch.temperature_centi));
            errs++;
          end
          if (result_ch.out_of_range !== want.flag) begin
            $error("out_of_range: expected %0b, got %0b", want.flag, result_ch.out_of_range);
            errs++;
          end
        end
      end
      // One long hold-off while the sender keeps offering, to back the pipeline up.
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && results_in >= HOLD_AFTER && sample_ch.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 6);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_thermistor_adc_to_temperature: FAIL");
      $finish;
    end
  end

  // Stimulus and configuration sequence.
  initial begin
    sample_ch.valid       = 1'b0;
    sample_ch.adc_reading = '0;
    result_ch.ready       = 1'b0;
    cfg_write             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    rst                   = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Default fit straight out of reset: ends, midpoint and alternating bits.
    readings_q = '{12'd0, 12'd1, 12'd2047, 12'd2048, 12'd2049, 12'd4094, 12'd4095,
                   12'haaa, 12'h555, 12'd1024, 12'd3072};
    settle();

    // Linear formula, including saturation at the top of the scale.
    write_reg(REG_MODE, 26'd1);
    readings_q = '{12'd0, 12'd4095, 12'd705, 12'd1722, 12'haaa};
    settle();

    // Mode bits above bit 0 are ignored, and a write past the list is dropped.
    write_reg(REG_MODE, 26'h3fffffe);
    write_reg(REG_SPARE, 26'h1234567);
    write_reg(REG_NUM_ONE, '0);
    write_reg(REG_NUM_TWO, '0);
    write_reg(REG_NUM_THREE, '0);
    write_reg(REG_DEN_ONE, COEF_MIN);
    write_reg(REG_DEN_TWO, COEF_MIN);
    write_reg(REG_OFFSET, COEF_MAX);
    // Saturation high at mid scale, a non-positive denominator at the top.
    readings_q = '{12'd0, 12'd2048, 12'd4095};
    settle();
    write_reg(REG_OFFSET, COEF_MIN);
    // Saturation low.
    readings_q = '{12'd2048, 12'd1000};
    settle();

    // Random phases: mostly fits near the default, some wild, some at the extremes.
    for (int ph = 0; ph < 10; ph++) begin
      int kind;
      logic [REG_W-1:0] mode_bits;
      kind      = $urandom_range(0, 9);
      mode_bits = REG_W'($urandom_range(0, (1 << REG_W) - 1));
      mode_bits[0] = ($urandom_range(0, 3) == 0);
      idle_on   = (ph % 3 != 2);
      write_reg(REG_MODE, mode_bits);
      for (int k = 0; k < 6; k++) begin
        logic [REG_W-1:0] v;
        if (kind < 6) begin
          v = nudge(FIT_DEFAULT[k]);
        end else if (kind < 8) begin
          v = REG_W'($urandom_range(0, (1 << REG_W) - 1));
        end else begin
          case ($urandom_range(0, 2))
            0: v = COEF_MIN;
            1: v = COEF_MAX;
            default: v = '0;
          endcase
        end
        write_reg(COEF_REGS[k], v);
      end
      for (int n = 0; n < 64; n++) readings_q.push_back(pick_reading());
      settle();
    end

    // Closing stretch at full rate on the default fit.
    calm = 1'b1;
    write_reg(REG_MODE, '0);
    for (int k = 0; k < 6; k++) write_reg(COEF_REGS[k], FIT_DEFAULT[k][REG_W-1:0]);
    for (int n = 0; n < 40; n++) readings_q.push_back(pick_reading());
    settle();

    repeat (40) @(posedge clk);
    if (errs == 0) begin
      $display("tb_thermistor_adc_to_temperature: PASS");
    end else begin
      $display("tb_thermistor_adc_to_temperature: FAIL");
    end
    $finish;
  end

endmodule
